// File: hw/rtl/ssid_pkg.sv
package ssid_pkg;

    localparam int unsigned KEY_W    = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 5;
    localparam int unsigned M_DATA_W = 8;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DUP     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd3;

    typedef struct packed {
        logic cmp;
        logic ins;
        logic del;
    } ssid_ctl_t;

endpackage

// File: hw/rtl/ssid_cell.sv
module ssid_cell (
    input  logic                             aclk,
    input  ssid_pkg::ssid_ctl_t              ctl,
    input  logic                             in_use,
    input  logic [ssid_pkg::KEY_W-1:0]       probe,
    input  logic [ssid_pkg::KEY_W-1:0]       key,
    input  logic [ssid_pkg::KEY_W-1:0]       left_entry,
    input  logic [ssid_pkg::KEY_W-1:0]       right_entry,
    input  logic                             left_lt,
    output logic [ssid_pkg::KEY_W-1:0]       entry,
    output logic                             lt,
    output logic                             eq
);
    import ssid_pkg::*;

    logic [KEY_W-1:0] entry_reg;
    logic [KEY_W-1:0] entry_next;
    logic             lt_reg;
    logic             eq_reg;

    always_comb begin
        entry_next = entry_reg;
        if (ctl.ins && !lt_reg) begin
            entry_next = left_lt ? key : left_entry;
        end else if (ctl.del && !lt_reg) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        if (ctl.cmp) begin
            lt_reg <= in_use && ($signed(entry_reg) < $signed(probe));
            eq_reg <= in_use && (entry_reg == probe);
        end
    end

    assign entry = entry_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule

// File: hw/rtl/sorted_set_insert_delete_core.sv
// Each accepted command item moves the sequencer to the apply step, which registers the
// result item and blocks new items; all cells compare on the accept edge, and in the apply
// step the entries from the insert or delete point onward shift by one place. The apply
// step waits while an unaccepted result still holds the output register.
// Reset (aresetn low, synchronous): clears the count, the sequencer and the output valid;
// stored values are left as they are and are read only after being written.
module sorted_set_insert_delete_core #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [ssid_pkg::KEY_W-1:0]         s_tdata,  // [31:0] value
    input  logic                               s_tuser,  // [0] command
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ssid_pkg::M_DATA_W-1:0]      m_tdata   // [1:0] status, [6:2] count
);
    import ssid_pkg::*;

    localparam int unsigned CW = $clog2(CAPACITY + 1);

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_APPLY = 1'b1;

    logic                 state_reg;
    logic                 state_next;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic                 cmd_reg;
    logic [KEY_W-1:0]     value_reg;
    logic                 m_valid_reg;
    logic [STATUS_W-1:0]  m_status_reg;
    logic [COUNT_W-1:0]   m_count_reg;
    logic [STATUS_W-1:0]  status_next;
    logic [CW+COUNT_W-1:0] count_wide;

    logic [KEY_W-1:0]     ent [CAPACITY];
    logic [CAPACITY-1:0]  lt_vec;
    logic [CAPACITY-1:0]  eq_vec;
    ssid_ctl_t            ctl;

    logic accept;
    logic advance;
    logic hit;
    logic full;
    logic do_ins;
    logic do_del;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign advance  = (state_reg == S_APPLY) && (!m_valid_reg || m_tready);
    assign hit      = |eq_vec;
    assign full     = (count_reg == CW'(CAPACITY));
    assign do_ins   = advance && (cmd_reg == CMD_INSERT) && !hit && !full;
    assign do_del   = advance && (cmd_reg == CMD_DELETE) && hit;

    assign ctl = '{cmp: accept, ins: do_ins, del: do_del};

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [KEY_W-1:0] left_e;
        logic [KEY_W-1:0] right_e;
        logic             left_l;
        if (i == 0) begin : g_first
            assign left_e = value_reg;
            assign left_l = 1'b1;
        end else begin : g_mid
            assign left_e = ent[i-1];
            assign left_l = lt_vec[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_e = value_reg;
        end else begin : g_inner
            assign right_e = ent[i+1];
        end
        ssid_cell u_cell (
            .aclk        (aclk),
            .ctl         (ctl),
            .in_use      (CW'(i) < count_reg),
            .probe       (s_tdata),
            .key         (value_reg),
            .left_entry  (left_e),
            .right_entry (right_e),
            .left_lt     (left_l),
            .entry       (ent[i]),
            .lt          (lt_vec[i]),
            .eq          (eq_vec[i])
        );
    end

    always_comb begin
        count_next  = count_reg;
        status_next = STATUS_DONE;
        if (cmd_reg == CMD_INSERT) begin
            if (hit) begin
                status_next = STATUS_DUP;
            end else if (full) begin
                status_next = STATUS_FULL;
            end else begin
                count_next = count_reg + CW'(1);
            end
        end else begin
            if (hit) begin
                count_next = count_reg - CW'(1);
            end else begin
                status_next = STATUS_MISSING;
            end
        end
    end

    assign count_wide = {{COUNT_W{1'b0}}, count_next};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY: begin
                if (advance) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (advance) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg   <= s_tuser;
            value_reg <= s_tdata;
        end
        if (advance) begin
            m_status_reg <= status_next;
            m_count_reg  <= count_wide[COUNT_W-1:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_count_reg, m_status_reg};

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("count exceeds capacity");

    a_single_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_APPLY) |-> $onehot0(eq_vec))
        else $error("more than one cell matches");

    a_sorted_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_APPLY) |-> (((lt_vec >> 1) & ~lt_vec) == '0))
        else $error("less-than flags not contiguous");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == S_APPLY))
        else $error("result without apply step");
`endif

endmodule
